FILE: hdl/trsto_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsto_pkg: shared types and constants
// Event kinds, machine state codes, status codes and the decoded request.
// ----------------------------------------------------------------------------
package trsto_pkg;

  localparam int unsigned NUM_COUNTERS = 9;
  localparam logic [31:0] COUNTER_CEILING_DEFAULT = 32'hFFFF_FFFF;
  localparam logic [31:0] DEADLINE_RESET = 32'd10000000;

  localparam logic [2:0] EV_SUBMIT  = 3'd0;
  localparam logic [2:0] EV_TICK    = 3'd1;
  localparam logic [2:0] EV_CONSUME = 3'd2;
  localparam logic [2:0] EV_CLAIM   = 3'd3;
  localparam logic [2:0] EV_PUBLISH = 3'd4;

  localparam logic [3:0] ST_IDLE        = 4'd1;
  localparam logic [3:0] ST_SUBMIT      = 4'd2;
  localparam logic [3:0] ST_BUSY        = 4'd3;
  localparam logic [3:0] ST_SUBMITTED   = 4'd4;
  localparam logic [3:0] ST_RUNNING     = 4'd5;
  localparam logic [3:0] ST_READY       = 4'd6;
  localparam logic [3:0] ST_ACCEPTED    = 4'd7;
  localparam logic [3:0] ST_DISCARDED   = 4'd8;
  localparam logic [3:0] ST_TIMEOUT     = 4'd9;
  localparam logic [3:0] ST_FAILED      = 4'd10;
  localparam logic [3:0] ST_RETURN_IDLE = 4'd11;

  localparam logic [2:0] STS_OK      = 3'd0;
  localparam logic [2:0] STS_INVALID = 3'd1;
  localparam logic [2:0] STS_BUSY    = 3'd2;
  localparam logic [2:0] STS_PENDING = 3'd3;
  localparam logic [2:0] STS_NOTHING = 3'd4;
  localparam logic [2:0] STS_DISCARD = 3'd5;

  localparam logic [3:0] CODE_UNCONF   = 4'd1;
  localparam logic [3:0] CODE_TIMEOUT  = 4'd2;

  localparam int unsigned C_SUBMIT   = 0;
  localparam int unsigned C_REJ_BUSY = 1;
  localparam int unsigned C_REJ_PEND = 2;
  localparam int unsigned C_CLAIM    = 3;
  localparam int unsigned C_SUCCESS  = 4;
  localparam int unsigned C_FAILURE  = 5;
  localparam int unsigned C_TIMEOUT  = 6;
  localparam int unsigned C_DISCARD  = 7;
  localparam int unsigned C_CONSUME  = 8;

  localparam int unsigned IN_W  = 3 + 64 + 32 + 8 + 3 + 32 + 1 + 1 + 4 + 1 + 4;
  localparam int unsigned IN_TW = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_W = 3 + 4 + 4 + 4 + 32 + 8 + 3 + 32 + 64 + 64 + 32 + 2;
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic [7:0]  slot;
    logic [2:0]  provider;
    logic [31:0] date;
  } window_t;

  // decoded request handed from front to back
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] now_us;
    logic [31:0] generation;
    window_t     win;
    logic        sub_valid;
    logic [3:0]  provider_code;
    logic        expect_present;
    logic [3:0]  counter_select;
  } req_t;

endpackage

FILE: hdl/trsto_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsto_front: request intake
// Unpacks the input stream and checks submit validity, then queues requests.
// ----------------------------------------------------------------------------
module trsto_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [trsto_pkg::IN_TW-1:0]   s_tdata,
  output logic                          q_valid,
  input  logic                          q_ready,
  output trsto_pkg::req_t               q_req
);
  import trsto_pkg::*;

  req_t   dec;
  req_t   fifo [2];
  logic   wr_ptr;
  logic   rd_ptr;
  logic [1:0] count;
  logic   push;
  logic   pop;

  always_comb begin
    dec.kind           = s_tdata[2:0];
    dec.now_us         = s_tdata[66:3];
    dec.generation     = s_tdata[98:67];
    dec.win.slot       = s_tdata[106:99];
    dec.win.provider   = s_tdata[109:107];
    dec.win.date       = s_tdata[141:110];
    dec.sub_valid      = (s_tdata[98:67] != 32'd0) && !s_tdata[106] &&
                         (s_tdata[109:107] != 3'd0) && s_tdata[142] && s_tdata[143];
    dec.provider_code  = s_tdata[147:144];
    dec.expect_present = s_tdata[148];
    dec.counter_select = s_tdata[152:149];
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_req    = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("push into full queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 2'd1) else $error("count lost push");
endmodule

FILE: hdl/trsto_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trsto_back: mailbox engine
// Carries out one request per cycle while the output skid has room, against
// the slot state, and registers the result into a two-entry output skid.
// ----------------------------------------------------------------------------
module trsto_back #(
  parameter logic [31:0] COUNTER_CEILING = trsto_pkg::COUNTER_CEILING_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  trsto_pkg::req_t               q_req,
  input  logic [31:0]                   deadline_us,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [trsto_pkg::OUT_TW-1:0]  m_tdata
);
  import trsto_pkg::*;

  logic [3:0]  fsm_state, fsm_state_next;
  logic [3:0]  event_note, event_note_next;
  logic [3:0]  last_outcome, last_outcome_next;
  logic [31:0] highest_gen, highest_gen_next;
  logic        f_flight, f_flight_next;
  logic        f_request, f_request_next;
  logic        f_result, f_result_next;
  logic [31:0] flight_gen, flight_gen_next;
  logic [63:0] flight_start, flight_start_next;
  window_t     flight_win, flight_win_next;
  logic [31:0] result_gen, result_gen_next;
  window_t     result_win, result_win_next;
  logic [63:0] res_start, res_start_next;
  logic [63:0] res_finish, res_finish_next;
  logic [31:0] counters [NUM_COUNTERS];
  logic [NUM_COUNTERS-1:0] bump;

  logic [2:0]  status;
  logic [31:0] o_gen;
  window_t     o_win;
  logic [63:0] o_start, o_finish;
  logic [63:0] elapsed;
  logic        accepts;
  logic [31:0] cnt_val;
  logic [OUT_TW-1:0] result_word;

  logic [OUT_TW-1:0] obuf [2];
  logic        owr, ord;
  logic [1:0]  ocount;
  logic        fire;

  assign q_ready = (ocount != 2'd2);
  assign fire    = q_valid && q_ready;
  assign elapsed = q_req.now_us - flight_start;
  assign accepts = (fsm_state == ST_IDLE) || (fsm_state == ST_TIMEOUT) ||
                   (fsm_state == ST_FAILED);

  always_comb begin
    fsm_state_next    = fsm_state;
    event_note_next   = event_note;
    last_outcome_next = last_outcome;
    highest_gen_next  = highest_gen;
    f_flight_next     = f_flight;
    f_request_next    = f_request;
    f_result_next     = f_result;
    flight_gen_next   = flight_gen;
    flight_start_next = flight_start;
    flight_win_next   = flight_win;
    result_gen_next   = result_gen;
    result_win_next   = result_win;
    res_start_next    = res_start;
    res_finish_next   = res_finish;
    bump     = '0;
    status   = STS_NOTHING;
    o_gen    = '0;
    o_win    = '0;
    o_start  = '0;
    o_finish = '0;
    case (q_req.kind)
      EV_SUBMIT: begin
        if (!q_req.sub_valid) begin
          event_note_next = ST_BUSY;
          status = STS_INVALID;
        end else if (q_req.generation <= highest_gen) begin
          status = STS_INVALID;
        end else if (f_result) begin
          bump[C_REJ_PEND] = 1'b1;
          event_note_next = ST_BUSY;
          status = STS_PENDING;
        end else if (f_flight || f_request || !accepts) begin
          bump[C_REJ_BUSY] = 1'b1;
          event_note_next = ST_BUSY;
          status = STS_BUSY;
        end else begin
          f_flight_next     = 1'b1;
          f_request_next    = 1'b1;
          highest_gen_next  = q_req.generation;
          flight_gen_next   = q_req.generation;
          flight_win_next   = q_req.win;
          flight_start_next = q_req.now_us;
          fsm_state_next    = ST_SUBMITTED;
          bump[C_SUBMIT]    = 1'b1;
          event_note_next   = ST_SUBMIT;
          status = STS_OK;
        end
      end
      EV_TICK: begin
        if (f_flight && (q_req.now_us > flight_start) &&
            (elapsed >= {32'd0, deadline_us})) begin
          f_flight_next     = 1'b0;
          f_request_next    = 1'b0;
          flight_gen_next   = '0;
          flight_start_next = '0;
          flight_win_next   = '0;
          fsm_state_next    = ST_TIMEOUT;
          last_outcome_next = CODE_TIMEOUT;
          bump[C_TIMEOUT]   = 1'b1;
          event_note_next   = ST_TIMEOUT;
          status = STS_OK;
        end
      end
      EV_CONSUME: begin
        if (f_result) begin
          if (q_req.expect_present && (q_req.win != result_win)) begin
            bump[C_DISCARD] = 1'b1;
            event_note_next = ST_DISCARDED;
            status = STS_DISCARD;
          end else begin
            o_gen    = result_gen;
            o_win    = result_win;
            o_start  = res_start;
            o_finish = res_finish;
            bump[C_CONSUME] = 1'b1;
            event_note_next = ST_ACCEPTED;
            status = STS_OK;
          end
          f_result_next   = 1'b0;
          result_gen_next = '0;
          result_win_next = '0;
          res_start_next  = '0;
          res_finish_next = '0;
          fsm_state_next  = ST_IDLE;
        end
      end
      EV_CLAIM: begin
        if (f_request && (fsm_state == ST_SUBMITTED)) begin
          o_gen = flight_gen;
          o_win = flight_win;
          f_request_next  = 1'b0;
          fsm_state_next  = ST_RUNNING;
          bump[C_CLAIM]   = 1'b1;
          event_note_next = ST_RUNNING;
          status = STS_OK;
        end
      end
      EV_PUBLISH: begin
        if (!f_flight || (q_req.generation == 32'd0) ||
            (q_req.generation != flight_gen) || f_result) begin
          bump[C_DISCARD] = 1'b1;
          event_note_next = ST_DISCARDED;
          status = STS_DISCARD;
        end else begin
          result_gen_next = q_req.generation;
          result_win_next = flight_win;
          res_start_next  = flight_start;
          res_finish_next = q_req.now_us;
          f_result_next   = 1'b1;
          fsm_state_next  = ST_READY;
          if (q_req.provider_code == 4'd0) begin
            bump[C_SUCCESS] = 1'b1;
            event_note_next = ST_READY;
          end else begin
            bump[C_FAILURE] = 1'b1;
            event_note_next = ST_FAILED;
          end
          last_outcome_next = q_req.provider_code;
          f_flight_next     = 1'b0;
          flight_gen_next   = '0;
          flight_start_next = '0;
          flight_win_next   = '0;
          status = STS_OK;
        end
      end
      default: begin
        status = STS_NOTHING;
      end
    endcase
  end

  // counters report the value after this request's update
  always_comb begin
    cnt_val = '0;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      if (q_req.counter_select == 4'(i)) begin
        cnt_val = (bump[i] && (counters[i] < COUNTER_CEILING)) ?
                  counters[i] + 32'd1 : counters[i];
      end
    end
  end

  assign result_word = {{(OUT_TW-OUT_W){1'b0}},
                        f_result_next, f_flight_next,
                        cnt_val, o_finish, o_start,
                        o_win.date, o_win.provider, o_win.slot, o_gen,
                        last_outcome_next, event_note_next, fsm_state_next, status};

  always_ff @(posedge clk) begin
    if (fire) begin
      obuf[owr] <= result_word;
    end
    if (rst) begin
      fsm_state    <= ST_IDLE;
      event_note   <= ST_RETURN_IDLE;
      last_outcome <= CODE_UNCONF;
      highest_gen  <= '0;
      f_flight     <= 1'b0;
      f_request    <= 1'b0;
      f_result     <= 1'b0;
      flight_gen   <= '0;
      flight_start <= '0;
      flight_win   <= '0;
      result_gen   <= '0;
      result_win   <= '0;
      res_start    <= '0;
      res_finish   <= '0;
      for (int i = 0; i < NUM_COUNTERS; i++) counters[i] <= '0;
      owr    <= 1'b0;
      ord    <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (fire) begin
        fsm_state    <= fsm_state_next;
        event_note   <= event_note_next;
        last_outcome <= last_outcome_next;
        highest_gen  <= highest_gen_next;
        f_flight     <= f_flight_next;
        f_request    <= f_request_next;
        f_result     <= f_result_next;
        flight_gen   <= flight_gen_next;
        flight_start <= flight_start_next;
        flight_win   <= flight_win_next;
        result_gen   <= result_gen_next;
        result_win   <= result_win_next;
        res_start    <= res_start_next;
        res_finish   <= res_finish_next;
        for (int i = 0; i < NUM_COUNTERS; i++) begin
          if (bump[i] && (counters[i] < COUNTER_CEILING)) counters[i] <= counters[i] + 32'd1;
        end
        owr <= ~owr;
      end
      if (m_tvalid && m_tready) ord <= ~ord;
      ocount <= ocount + {1'b0, fire} - {1'b0, m_tvalid && m_tready};
    end
  end

  assign m_tvalid = (ocount != 2'd0);
  assign m_tdata  = obuf[ord];

  a_one_bump: assert property (@(posedge clk) disable iff (rst) $onehot0(bump))
    else $error("more than one counter bumped");
  a_result_clears_flight: assert property (@(posedge clk) disable iff (rst)
    f_result |-> !(f_flight && fsm_state == ST_READY)) else $error("flight and result");
  a_request_needs_flight: assert property (@(posedge clk) disable iff (rst)
    (fsm_state == ST_SUBMITTED) |-> f_flight) else $error("submitted without flight");
  a_ocount: assert property (@(posedge clk) disable iff (rst) ocount != 2'd3)
    else $error("output skid overflow");
endmodule

FILE: hdl/tagged_request_slot_with_timeout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tagged_request_slot_with_timeout: generation-tagged request mailbox
// a request's result passes through the request queue, then the engine output
// register; the mailbox takes one request per cycle while the output skid has
// room. reset (rst, synchronous) empties both queues,
// clears the slot and counters and reloads deadline_us to 10000000.
// ----------------------------------------------------------------------------
module tagged_request_slot_with_timeout #(
  parameter logic [31:0] COUNTER_CEILING = trsto_pkg::COUNTER_CEILING_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [31:0]                   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // req_type, now_us, generation, window_slot, window_provider, window_date,
  // has_host_and_path, epoch_trusted, provider_code, expect_present,
  // counter_select
  input  logic [trsto_pkg::IN_TW-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status, machine_state, event_note, last_provider_code, item_generation,
  // out_slot, out_provider, out_date, start_time, finish_time,
  // counter_value, busy_flags
  output logic [trsto_pkg::OUT_TW-1:0]  m_tdata
);
  import trsto_pkg::*;

  logic        q_valid;
  logic        q_ready;
  req_t        q_req;
  logic [31:0] deadline_us;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadline_us <= DEADLINE_RESET;
    end else if (cfg_valid) begin
      deadline_us <= cfg_data;
    end
  end

  trsto_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_req    (q_req)
  );

  trsto_back #(.COUNTER_CEILING(COUNTER_CEILING)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_req       (q_req),
    .deadline_us (deadline_us),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the generation-tagged request mailbox
// Drives submit, tick, consume, claim and publish requests, runs a behavioral
// mailbox model beside the block and compares every result with the model's reply.
// ----------------------------------------------------------------------------
module tb_top;
  import trsto_pkg::*;

  localparam int OUT_BITS = 3 + 4 + 4 + 4 + 32 + 8 + 3 + 32 + 64 + 64 + 32 + 2;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] now;
    logic [31:0] gen;
    logic [7:0]  slot;
    logic [2:0]  prov;
    logic [31:0] date;
    logic        hostpath;
    logic        trusted;
    logic [3:0]  code;
    logic        expect_win;
    logic [3:0]  sel;
  } event_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  state;
    logic [3:0]  note;
    logic [3:0]  outcome;
    logic [31:0] gen;
    logic [7:0]  slot;
    logic [2:0]  prov;
    logic [31:0] date;
    logic [63:0] started;
    logic [63:0] finished;
    logic [31:0] counter;
    logic [1:0]  flags;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TW-1:0] m_tdata;

  // mailbox model state
  logic [31:0] m_deadline;
  logic [3:0]  m_state, m_note, m_outcome;
  logic [31:0] m_highest, m_fgen, m_rgen;
  logic        m_flight, m_request, m_result;
  logic [63:0] m_fstart, m_rstart, m_rfinish;
  logic [42:0] m_fwin, m_rwin;
  logic [31:0] m_count [NUM_COUNTERS];

  reply_t expected_replies[$];
  int errors = 0;
  int send_idle = 0;
  int recv_stall = 0;
  logic [63:0] clock_us = '0;
  logic [31:0] next_gen = 32'd1;

  always #5 clk = ~clk;

  tagged_request_slot_with_timeout i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  function automatic void bump(int idx);
    if (m_count[idx] < 32'hFFFF_FFFF) m_count[idx] = m_count[idx] + 32'd1;
  endfunction

  function automatic void mailbox_reset();
    m_deadline = DEADLINE_RESET;
    m_state = ST_IDLE;
    m_note = ST_RETURN_IDLE;
    m_outcome = CODE_UNCONF;
    m_highest = 0; m_fgen = 0; m_rgen = 0;
    m_flight = 0; m_request = 0; m_result = 0;
    m_fstart = 0; m_rstart = 0; m_rfinish = 0;
    m_fwin = 0; m_rwin = 0;
    for (int i = 0; i < NUM_COUNTERS; i++) m_count[i] = 0;
  endfunction

  function automatic reply_t mailbox_step(event_t e);
    reply_t r;
    logic [42:0] w;
    logic valid, accepts;
    w = {e.slot, e.prov, e.date};
    r = '0;
    r.status = STS_NOTHING;
    case (e.kind)
      EV_SUBMIT: begin
        valid = e.gen != 0 && !e.slot[7] && e.prov != 0 && e.hostpath && e.trusted;
        accepts = m_state == ST_IDLE || m_state == ST_TIMEOUT || m_state == ST_FAILED;
        if (!valid) begin
          m_note = ST_BUSY; r.status = STS_INVALID;
        end else if (e.gen <= m_highest) begin
          r.status = STS_INVALID;
        end else if (m_result) begin
          bump(C_REJ_PEND); m_note = ST_BUSY; r.status = STS_PENDING;
        end else if (m_flight || m_request || !accepts) begin
          bump(C_REJ_BUSY); m_note = ST_BUSY; r.status = STS_BUSY;
        end else begin
          m_flight = 1; m_request = 1;
          m_highest = e.gen; m_fgen = e.gen; m_fwin = w; m_fstart = e.now;
          m_state = ST_SUBMITTED; bump(C_SUBMIT); m_note = ST_SUBMIT;
          r.status = STS_OK;
        end
      end
      EV_TICK: begin
        if (m_flight && e.now > m_fstart && (e.now - m_fstart) >= {32'd0, m_deadline}) begin
          m_flight = 0; m_request = 0; m_fgen = 0; m_fstart = 0; m_fwin = 0;
          m_state = ST_TIMEOUT; m_outcome = CODE_TIMEOUT; bump(C_TIMEOUT);
          m_note = ST_TIMEOUT; r.status = STS_OK;
        end
      end
      EV_CONSUME: begin
        if (m_result) begin
          if (e.expect_win && w != m_rwin) begin
            bump(C_DISCARD); m_note = ST_DISCARDED; r.status = STS_DISCARD;
          end else begin
            r.gen = m_rgen;
            {r.slot, r.prov, r.date} = m_rwin;
            r.started = m_rstart; r.finished = m_rfinish;
            bump(C_CONSUME); m_note = ST_ACCEPTED; r.status = STS_OK;
          end
          m_result = 0; m_rgen = 0; m_rwin = 0; m_rstart = 0; m_rfinish = 0;
          m_state = ST_IDLE;
        end
      end
      EV_CLAIM: begin
        if (m_request && m_state == ST_SUBMITTED) begin
          r.gen = m_fgen;
          {r.slot, r.prov, r.date} = m_fwin;
          m_request = 0; m_state = ST_RUNNING; bump(C_CLAIM);
          m_note = ST_RUNNING; r.status = STS_OK;
        end
      end
      EV_PUBLISH: begin
        if (!m_flight || e.gen == 0 || e.gen != m_fgen || m_result) begin
          bump(C_DISCARD); m_note = ST_DISCARDED; r.status = STS_DISCARD;
        end else begin
          m_rgen = e.gen; m_rwin = m_fwin; m_rstart = m_fstart; m_rfinish = e.now;
          m_result = 1; m_state = ST_READY;
          if (e.code == 0) begin
            bump(C_SUCCESS); m_note = ST_READY;
          end else begin
            bump(C_FAILURE); m_note = ST_FAILED;
          end
          m_outcome = e.code;
          m_flight = 0; m_fgen = 0; m_fstart = 0; m_fwin = 0;
          r.status = STS_OK;
        end
      end
      default: ;
    endcase
    r.state = m_state;
    r.note = m_note;
    r.outcome = m_outcome;
    r.counter = e.sel < NUM_COUNTERS ? m_count[e.sel] : 32'd0;
    r.flags = {m_result, m_flight};
    return r;
  endfunction

  function automatic event_t random_event(logic [2:0] kind);
    event_t e;
    e.kind = kind;
    e.now = {$urandom, $urandom};
    e.gen = $urandom;
    e.slot = 8'($urandom);
    e.prov = 3'($urandom);
    e.date = $urandom;
    e.hostpath = 1'($urandom);
    e.trusted = 1'($urandom);
    e.code = 4'($urandom);
    e.expect_win = 1'($urandom);
    e.sel = 4'($urandom_range(0, 9));
    return e;
  endfunction

  task automatic send_request(event_t e);
    while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= IN_TW'({e.sel, e.expect_win, e.code, e.trusted, e.hostpath, e.date,
                       e.prov, e.slot, e.gen, e.now, e.kind});
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_replies.push_back(mailbox_step(e));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_deadline(logic [31:0] value);
    wait_drained();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    m_deadline = value;
  endtask

  // well-formed submit with fresh generation and time that never moves backward
  function automatic event_t good_submit();
    event_t e;
    e = random_event(EV_SUBMIT);
    e.gen = next_gen;
    next_gen = next_gen + $urandom_range(1, 3);
    e.slot[7] = 1'b0;
    if (e.prov == 3'd0) e.prov = 3'd1;
    e.hostpath = 1'b1; e.trusted = 1'b1;
    clock_us = clock_us + $urandom_range(0, 50);
    e.now = clock_us;
    return e;
  endfunction

  function automatic event_t timed(logic [2:0] kind, int step);
    event_t e;
    e = random_event(kind);
    clock_us = clock_us + step;
    e.now = clock_us;
    return e;
  endfunction

  task automatic test_directed();
    event_t e;
    logic [31:0] g;
    for (int k = 0; k < 8; k++) send_request(random_event(3'(k)));
    e = good_submit(); e.gen = '0; send_request(e);
    e = good_submit(); e.slot = 8'h80; send_request(e);
    e = good_submit(); e.prov = 3'd0; send_request(e);
    e = good_submit(); e.hostpath = 1'b0; send_request(e);
    e = good_submit(); g = e.gen; e.slot = 8'h7F; e.prov = 3'd7; e.date = '1; send_request(e);
    e = good_submit(); e.gen = g; send_request(e);
    e = good_submit(); send_request(e);
    send_request(timed(EV_CLAIM, 1));
    e = timed(EV_PUBLISH, 1); e.gen = g + 32'd1; send_request(e);
    e = timed(EV_PUBLISH, 1); e.gen = g; e.code = 4'd0; send_request(e);
    e = good_submit(); send_request(e);
    e = timed(EV_CONSUME, 1); e.expect_win = 1'b1; e.slot = 8'h7F; e.prov = 3'd7;
    e.date = '1;
    send_request(e);
    e = good_submit(); send_request(e);
    e = timed(EV_PUBLISH, 1); e.gen = next_gen - 32'd1; send_request(e);
    e = random_event(EV_SUBMIT); e.gen = '1; e.slot = '0; e.prov = 3'd1;
    e.hostpath = 1'b1; e.trusted = 1'b1; send_request(e);
    e = random_event(EV_TICK); e.now = '1; e.sel = 4'd15; send_request(e);
  endtask

  task automatic test_timeouts();
    event_t e;
    write_deadline(32'd1);
    for (int i = 0; i < 20; i++) begin
      send_request(good_submit());
      e = timed(EV_TICK, 0); send_request(e);
      send_request(timed(EV_TICK, $urandom_range(0, 2)));
    end
    write_deadline(32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) begin
      send_request(good_submit());
      send_request(timed(EV_TICK, $urandom_range(0, 100)));
      e = timed(EV_TICK, 0); e.now = clock_us + 64'hFFFF_FFFF; send_request(e);
    end
  endtask

  task automatic random_round();
    event_t e;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      send_request(good_submit());
      if ($urandom_range(0, 5) != 0) send_request(timed(EV_CLAIM, $urandom_range(0, 5)));
      if ($urandom_range(0, 7) == 0)
        send_request(timed(EV_TICK, $urandom_range(0, 2) * m_deadline));
      e = timed(EV_PUBLISH, $urandom_range(0, 20));
      e.gen = $urandom_range(0, 9) == 0 ? $urandom : next_gen - 32'd1;
      e.code = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'd0;
      send_request(e);
      e = timed(EV_CONSUME, 1);
      e.expect_win = 1'($urandom);
      if ($urandom_range(0, 2) != 0) {e.slot, e.prov, e.date} = m_rwin;
      send_request(e);
    end else begin
      e = random_event(3'($urandom_range(0, 7)));
      if (e.kind == EV_SUBMIT && $urandom_range(0, 1)) e = good_submit();
      send_request(e);
    end
  endtask

  task automatic test_random(int rounds);
    for (int i = 0; i < rounds; i++) random_round();
  endtask

  // reply checker
  always @(posedge clk) begin
    reply_t exp_r, got;
    if (!rst && m_tvalid && m_tready) begin
      {got.flags, got.counter, got.finished, got.started, got.date, got.prov, got.slot,
       got.gen, got.outcome, got.note, got.state, got.status} = m_tdata[OUT_BITS-1:0];
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply %h", $time, m_tdata);
        errors++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (got != exp_r) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= !(recv_stall > 0 && $urandom_range(0, 99) < recv_stall);
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    mailbox_reset();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    write_deadline(32'd0);
    test_random(40);
    test_timeouts();
    write_deadline(32'd30);
    send_idle = 66;
    test_random(120);
    wait_drained();
    send_idle = 0; recv_stall = 66;
    test_random(120);
    send_idle = 37; recv_stall = 37;
    write_deadline(32'd5);
    test_random(120);
    send_idle = 0; recv_stall = 0;
    write_deadline(DEADLINE_RESET);
    test_random(40);
    wait_drained();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/trsto_pkg.sv
hdl/trsto_front.sv
hdl/trsto_back.sv
hdl/tagged_request_slot_with_timeout.sv
verif/tb_top.sv
